FILE: hdl/sgd_momentum_update_unit_defines.svh
// ----------------------------------------------------------------------------
// SGD momentum update unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH
`define SGD_MOMENTUM_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication
`define SGDMU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SGDMU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Delayed implication
`define SGDMU_ASSERT_DLY3(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##3 (cons)) \
		else $error(msg);

`endif

FILE: hdl/sgdmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum update package
// Widths, register codes, reset values and the fixed-point helpers.
// ----------------------------------------------------------------------------
package sgdmu_pkg;

	localparam int DATA_W        = 16;
	localparam int COEF_W        = 16;
	localparam int IDX_W         = 10;
	localparam int CFG_IDX_W     = 2;
	localparam int NUM_ELEMS_DEF = 1024;

	// width of a rounded coefficient product and of a widened sum
	localparam int TERM_W = DATA_W + 2;
	localparam int SUM_W  = DATA_W + 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DECAY    = 2'd2;

	// register reset values
	localparam logic [COEF_W-1:0] LEARNING_RATE_RST   = 16'd655;
	localparam logic [COEF_W-1:0] MOMENTUM_FACTOR_RST = 16'd58982;
	localparam logic [COEF_W-1:0] WEIGHT_DECAY_RST    = 16'd0;

	typedef struct packed {
		logic [COEF_W-1:0] learning_rate;
		logic [COEF_W-1:0] momentum_factor;
		logic [COEF_W-1:0] weight_decay;
	} coef_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     ovf;
	} sat_t;

	// Q0.16 coefficient times Q4.12 value, rounded half up to an 18-bit Q6.12
	function automatic logic signed [TERM_W-1:0] mul_round(
		input logic [COEF_W-1:0]        coef,
		input logic signed [DATA_W-1:0] val
	);
		logic signed [COEF_W+DATA_W:0]   prod;
		logic signed [COEF_W+DATA_W+1:0] biased;
		prod   = $signed({1'b0, coef}) * val;
		biased = $signed({prod[COEF_W+DATA_W], prod}) + $signed(34'sd32768);
		return biased[COEF_W+DATA_W+1:COEF_W];
	endfunction

	// clamp a widened sum to 16 bits and flag it
	function automatic sat_t sat16(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > $signed(19'sd32767)) begin
			r.val = 16'sh7FFF;
			r.ovf = 1'b1;
		end else if (v < $signed(-19'sd32768)) begin
			r.val = 16'sh8000;
			r.ovf = 1'b1;
		end else begin
			r.val = v[DATA_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_data(input logic signed [DATA_W-1:0] v);
		return $signed({{(SUM_W-DATA_W){v[DATA_W-1]}}, v});
	endfunction

	function automatic logic signed [SUM_W-1:0] ext_term(input logic signed [TERM_W-1:0] v);
		return $signed({{(SUM_W-TERM_W){v[TERM_W-1]}}, v});
	endfunction

endpackage

FILE: hdl/sgdmu_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum store
// One-write one-read synchronous memory, read-first, with a zeroing sweep
// after reset that holds off the pipeline until every entry is cleared.
// ----------------------------------------------------------------------------
module sgdmu_mem #(
	parameter  int NUM_ELEMS = sgdmu_pkg::NUM_ELEMS_DEF,
	localparam int AW        = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [AW-1:0]                     rd_addr,
	output logic signed [sgdmu_pkg::DATA_W-1:0] rd_data,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] wr_data,
	output logic                              clearing
);
	import sgdmu_pkg::*;

	logic signed [DATA_W-1:0] mem [NUM_ELEMS];
	logic [AW-1:0]            clr_addr_q;
	logic                     clearing_q;

	// advance the clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(NUM_ELEMS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// write port: zero during the sweep, otherwise write-back
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

FILE: hdl/sgdmu_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum update pipeline
// Three stages: gradient plus decay, momentum read-modify-write with
// forwarding, parameter step; each stage has one multiplier.
// ----------------------------------------------------------------------------
module sgdmu_pipe #(
	parameter  int NUM_ELEMS = sgdmu_pkg::NUM_ELEMS_DEF,
	localparam int AW        = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [sgdmu_pkg::IDX_W-1:0]         elem_index,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] param_value,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] grad_value,
	input  sgdmu_pkg::coef_t                    coef,
	output logic                                rd_en,
	output logic [AW-1:0]                       rd_addr,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] rd_data,
	output logic                                wr_en,
	output logic [AW-1:0]                       wr_addr,
	output logic signed [sgdmu_pkg::DATA_W-1:0] wr_data,
	output logic                                done,
	output logic signed [sgdmu_pkg::DATA_W-1:0] new_param,
	output logic signed [sgdmu_pkg::DATA_W-1:0] new_momentum,
	output logic                                clipped
);
	import sgdmu_pkg::*;

	localparam int CW = 17;

	// stage 0 (accept cycle)
	logic [CW-1:0]            idx_w;
	logic                     in_range;
	logic signed [TERM_W-1:0] wd_term;
	sat_t                     g_sat;

	// stage 1
	logic                     v_s1;
	logic                     inr_s1;
	logic [AW-1:0]            addr_s1;
	logic signed [DATA_W-1:0] param_s1;
	logic signed [DATA_W-1:0] g_s1;
	logic                     clip_s1;
	logic                     fwd;
	logic signed [DATA_W-1:0] old_m;
	logic signed [TERM_W-1:0] mf_term;
	sat_t                     m_sat;

	// stage 2
	logic                     v_s2;
	logic                     inr_s2;
	logic [AW-1:0]            addr_s2;
	logic signed [DATA_W-1:0] param_s2;
	logic signed [DATA_W-1:0] m_s2;
	logic                     clip_s2;
	logic signed [TERM_W-1:0] lr_term;
	sat_t                     p_sat;

	// output
	logic                     done_q;
	logic signed [DATA_W-1:0] new_param_q;
	logic signed [DATA_W-1:0] new_momentum_q;
	logic                     clipped_q;

	// stage 0: range check, store read, decayed gradient
	always_comb begin
		idx_w    = CW'(elem_index);
		in_range = idx_w < CW'(NUM_ELEMS);
		wd_term  = mul_round(coef.weight_decay, param_value);
		g_sat    = sat16(ext_data(grad_value) + ext_term(wd_term));
	end

	assign rd_en   = accept;
	assign rd_addr = idx_w[AW-1:0];

	always_ff @(posedge clk) begin
		inr_s1   <= in_range;
		addr_s1  <= idx_w[AW-1:0];
		param_s1 <= param_value;
		g_s1     <= g_sat.val;
		clip_s1  <= g_sat.ovf;
	end

	// stage 1: take the momentum just written by the item ahead, if any
	always_comb begin
		fwd = v_s2 && inr_s2 && (addr_s2 == addr_s1);
		if (!inr_s1) begin
			old_m = '0;
		end else if (fwd) begin
			old_m = m_s2;
		end else begin
			old_m = rd_data;
		end
		mf_term = mul_round(coef.momentum_factor, old_m);
		m_sat   = sat16(ext_term(mf_term) + ext_data(g_s1));
	end

	// write back the new momentum at the end of stage 1
	assign wr_en   = v_s1 && inr_s1;
	assign wr_addr = addr_s1;
	assign wr_data = m_sat.val;

	always_ff @(posedge clk) begin
		inr_s2   <= inr_s1;
		addr_s2  <= addr_s1;
		param_s2 <= param_s1;
		m_s2     <= m_sat.val;
		clip_s2  <= clip_s1 || m_sat.ovf;
	end

	// stage 2: parameter step
	always_comb begin
		lr_term = mul_round(coef.learning_rate, m_s2);
		p_sat   = sat16(ext_data(param_s2) - ext_term(lr_term));
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			new_param_q    <= p_sat.val;
			new_momentum_q <= m_s2;
			clipped_q      <= clip_s2 || p_sat.ovf;
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	assign done         = done_q;
	assign new_param    = new_param_q;
	assign new_momentum = new_momentum_q;
	assign clipped      = clipped_q;

endmodule

FILE: hdl/sgd_momentum_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SGD momentum update unit
// SGD step with momentum and L2 weight decay on signed Q4.12 elements, one
// element per call; momenta live in an on-chip store indexed by element.
//
//   channel   handshake              payload
//   -------   --------------------   -----------------------------------------
//   command   start / busy           elem_index, param_value, grad_value
//   result    done (one-cycle)       new_param, new_momentum, clipped
//   config    cfg_we                 cfg_index, cfg_wdata
//
// An item is taken on every cycle with start high and busy low; its result
// shows with done after the stage 1, stage 2 and output registers, one item
// per cycle sustained. The momentum read-modify-write loop closes in one
// stage with a single bypass from the write-back register. After reset busy
// stays high while the store is swept to zero. Results cannot be held off.
// ----------------------------------------------------------------------------
`include "sgd_momentum_update_unit_defines.svh"

module sgd_momentum_update_unit #(
	parameter  int NUM_ELEMS = sgdmu_pkg::NUM_ELEMS_DEF,
	localparam int AW        = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [sgdmu_pkg::IDX_W-1:0]         elem_index,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] param_value,
	input  logic signed [sgdmu_pkg::DATA_W-1:0] grad_value,
	output logic                                done,
	output logic signed [sgdmu_pkg::DATA_W-1:0] new_param,
	output logic signed [sgdmu_pkg::DATA_W-1:0] new_momentum,
	output logic                                clipped,
	input  logic                                cfg_we,
	input  logic [sgdmu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sgdmu_pkg::COEF_W-1:0]        cfg_wdata
);
	import sgdmu_pkg::*;

	coef_t                    coef_q;
	logic                     clearing;
	logic                     accept;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.learning_rate   <= LEARNING_RATE_RST;
			coef_q.momentum_factor <= MOMENTUM_FACTOR_RST;
			coef_q.weight_decay    <= WEIGHT_DECAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEARNING_RATE:   coef_q.learning_rate   <= cfg_wdata;
				REG_MOMENTUM_FACTOR: coef_q.momentum_factor <= cfg_wdata;
				REG_WEIGHT_DECAY:    coef_q.weight_decay    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// hold off items during the store sweep
	assign busy   = clearing;
	assign accept = start && !clearing;

	sgdmu_pipe #(
		.NUM_ELEMS (NUM_ELEMS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.elem_index   (elem_index),
		.param_value  (param_value),
		.grad_value   (grad_value),
		.coef         (coef_q),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.done         (done),
		.new_param    (new_param),
		.new_momentum (new_momentum),
		.clipped      (clipped)
	);

	sgdmu_mem #(
		.NUM_ELEMS (NUM_ELEMS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	// checks
	`SGDMU_ASSERT_DLY3(a_result_follows, start && !busy, done, "item gave no result")
	`SGDMU_ASSERT_IMP(a_result_has_item, done, $past(start && !busy, 3), "result without item")
	`SGDMU_ASSERT_NXT(a_sweep_once, !busy, !busy, "store sweep restarted")

endmodule
